/* design/prct_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// prct_pkg: shared types and constants for the parity range count tree
// Field widths, action codes and the command/status bundles that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package prct_pkg;

  localparam int ACT_W      = 2;
  localparam int IDX_W      = 10;
  localparam int VAL_W      = 32;
  localparam int CNT_W      = 11;
  // Index fields are 10 bits, so no more than this many leaves are reachable.
  localparam int MAX_LEAVES = 1024;

  localparam logic [ACT_W-1:0] ACT_SET  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_EVEN = 2'd1;
  localparam logic [ACT_W-1:0] ACT_ODD  = 2'd2;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // latch the accepted item, clear the sum
    logic clr_en;    // write zero at the clear counter, advance it
    logic set_wr;    // write node +/- 1 on the set path, step to the parent
    logic q_left;    // read the node at the left cursor, advance it
    logic q_right;   // step the right cursor back, read that node
    logic q_shift;   // move both cursors up one level
    logic res_load;  // load the result register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clr_last;
    logic is_set;
    logic is_query;
    logic set_ok;
    logic range_ok;
    logic no_change;
    logic at_root;
    logic l_lt_r;
    logic l_odd;
    logic r_odd;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

/* design/prct_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// prct_ram: generic single-port-write, registered-read RAM
// One write and one read address per cycle; read data is registered and appears in the cycle after its address.
// ----------------------------------------------------------------------------
module prct_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* design/prct_dpath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// prct_dpath: node memory, tree cursors, accumulator and result register
// Bottom-up segment tree: leaf i sits at node LP+i, node p has children
// 2p and 2p+1, the root is node 1.
// ----------------------------------------------------------------------------
module prct_dpath #(
  parameter int ELEMENTS = 1024
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [prct_pkg::ACT_W-1:0] in_act,
  input  wire logic [prct_pkg::IDX_W-1:0] in_lo,
  input  wire logic [prct_pkg::IDX_W-1:0] in_hi,
  input  wire logic                       in_bit,
  input  wire prct_pkg::cmd_t             cmd,
  output prct_pkg::sts_t                  sts,
  input  wire logic                       out_ready,
  output logic                            out_valid,
  output logic [prct_pkg::CNT_W-1:0]      out_count,
  output logic                            out_err
);
  import prct_pkg::*;

  localparam int LEAVES = (ELEMENTS < MAX_LEAVES) ? ELEMENTS : MAX_LEAVES;
  localparam int LW     = (LEAVES > 1) ? $clog2(LEAVES) : 1;
  localparam int LP     = 2 ** LW;
  localparam int AW     = LW + 1;
  localparam int PW     = AW + 1;
  localparam int DEPTH  = 2 * LP;

  logic [ACT_W-1:0] act_r;
  logic [IDX_W-1:0] lo_r, hi_r;
  logic             bit_r;
  logic [AW-1:0]    a_r;
  logic [PW-1:0]    l_r, r_r;
  logic [PW-1:0]    r_dec;
  logic             first_r;
  logic             pend_r;
  logic [CNT_W-1:0] sum_r, sum_nxt;
  logic [AW-1:0]    clr_r;
  logic             out_valid_r;
  logic [CNT_W-1:0] out_count_r;
  logic             out_err_r;
  logic [CNT_W-1:0] even_cnt;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [CNT_W-1:0] ram_wdata, node_rd;

  prct_ram #(.WIDTH(CNT_W), .DEPTH(DEPTH)) u_nodes (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (node_rd)
  );

  assign r_dec = r_r - PW'(1);

  always_comb begin
    ram_we    = cmd.clr_en | cmd.set_wr;
    ram_waddr = cmd.clr_en ? clr_r : a_r;
    if (cmd.clr_en) begin
      ram_wdata = '0;
    end else if (bit_r) begin
      ram_wdata = node_rd + CNT_W'(1);
    end else begin
      ram_wdata = node_rd - CNT_W'(1);
    end
    if (cmd.q_left) begin
      ram_raddr = l_r[AW-1:0];
    end else if (cmd.q_right) begin
      ram_raddr = r_dec[AW-1:0];
    end else begin
      ram_raddr = a_r;
    end
  end

  always_comb begin
    sts.clr_last  = (clr_r == AW'(DEPTH - 1));
    sts.is_set    = (act_r == ACT_SET);
    sts.is_query  = (act_r == ACT_EVEN) || (act_r == ACT_ODD);
    sts.set_ok    = (32'(lo_r) < 32'(ELEMENTS));
    sts.range_ok  = (hi_r >= lo_r) && (32'(hi_r) < 32'(ELEMENTS));
    sts.no_change = first_r && (node_rd[0] == bit_r);
    sts.at_root   = (a_r == AW'(1));
    sts.l_lt_r    = (l_r < r_r);
    sts.l_odd     = l_r[0];
    sts.r_odd     = r_r[0];
    sts.out_free  = !out_valid_r || out_ready;
  end

  // Fold in the node read on the previous cycle.
  always_comb begin
    if (cmd.load) begin
      sum_nxt = '0;
    end else if (pend_r) begin
      sum_nxt = sum_r + node_rd;
    end else begin
      sum_nxt = sum_r;
    end
  end

  assign even_cnt = ({1'b0, hi_r} - {1'b0, lo_r}) + CNT_W'(1) - sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      pend_r      <= 1'b0;
      first_r     <= 1'b0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_en) begin
        clr_r <= clr_r + AW'(1);
      end
      pend_r <= cmd.q_left | cmd.q_right;
      sum_r  <= sum_nxt;
      if (cmd.load) begin
        first_r <= 1'b1;
      end else if (cmd.set_wr) begin
        first_r <= 1'b0;
      end
      if (cmd.res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_act;
      lo_r  <= in_lo;
      hi_r  <= in_hi;
      bit_r <= in_bit;
      a_r   <= {1'b1, in_lo[LW-1:0]};
      l_r   <= {1'b0, 1'b1, in_lo[LW-1:0]};
      r_r   <= {1'b0, 1'b1, in_hi[LW-1:0]} + PW'(1);
    end else begin
      if (cmd.set_wr) begin
        a_r <= a_r >> 1;
      end
      if (cmd.q_left) begin
        l_r <= l_r + PW'(1);
      end else if (cmd.q_right) begin
        r_r <= r_dec;
      end else if (cmd.q_shift) begin
        l_r <= l_r >> 1;
        r_r <= r_r >> 1;
      end
    end
    if (cmd.res_load) begin
      out_err_r <= !sts.range_ok;
      if (!sts.range_ok) begin
        out_count_r <= '0;
      end else if (act_r == ACT_ODD) begin
        out_count_r <= sum_r;
      end else begin
        out_count_r <= even_cnt;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_count = out_count_r;
  assign out_err   = out_err_r;

  // A decrement on the set path always finds a nonzero node.
  a_dec_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.set_wr && !bit_r |-> node_rd != '0)
    else $error("set path decrements a zero node");

  // The left cursor only reads while the window is still open.
  a_left_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.q_left |-> l_r < r_r)
    else $error("left read outside the query window");

  // The odd count never exceeds the leaf count.
  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |=> sum_r <= CNT_W'(LP))
    else $error("odd count beyond leaf count");

endmodule
`default_nettype wire

/* design/prct_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// prct_ctrl: sequencer for clear pass, set path walk and query walk
// ----------------------------------------------------------------------------
module prct_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire prct_pkg::sts_t sts,
  output prct_pkg::cmd_t      cmd
);
  import prct_pkg::*;

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_DECODE = 7'b0000100,
    ST_SET_RD = 7'b0001000,
    ST_SET_WR = 7'b0010000,
    ST_Q_STEP = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts.is_set) begin
          state_nxt = sts.set_ok ? ST_SET_RD : ST_IDLE;
        end else if (sts.is_query) begin
          state_nxt = sts.range_ok ? ST_Q_STEP : ST_DONE;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SET_RD: begin
        state_nxt = ST_SET_WR;
      end
      ST_SET_WR: begin
        if (sts.no_change) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.set_wr = 1'b1;
          state_nxt  = sts.at_root ? ST_IDLE : ST_SET_RD;
        end
      end
      ST_Q_STEP: begin
        if (!sts.l_lt_r) begin
          state_nxt = ST_DONE;
        end else if (sts.l_odd) begin
          cmd.q_left = 1'b1;
        end else if (sts.r_odd) begin
          cmd.q_right = 1'b1;
        end else begin
          cmd.q_shift = 1'b1;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

/* design/parity_range_count_tree.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// parity_range_count_tree: segment tree of odd-element counts
// Set items store the low bit of a value per element and update the tree
// path; query items return the odd or even count over an inclusive range.
// ----------------------------------------------------------------------------
// Sequence: a set is accepted and decoded, then reads and writes each node on
//   the path from its leaf up to the root; it writes nothing when the stored
//   bit already matches. A query runs accept, decode, one cursor move per
//   step (at most 3 moves per tree level), a final window check and the
//   result load; a bad range skips the cursor moves. A query also waits
//   while the result register still holds an unaccepted result.
// Throughput: one item at a time; the single read port of the node memory
//   paces both walks, and a new item is taken only once the last is done.
// Reset: a clearing pass writes zero to all 2*LP nodes before the first
//   item is accepted.
// ----------------------------------------------------------------------------
module parity_range_count_tree #(
  parameter int ELEMENTS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [9:0] left_index, [19:10] right_index, [51:20] value, [55:52] zero
  input  wire logic [55:0] in_tdata,
  // [1:0] action
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [10:0] count, [15:11] zero
  output logic [15:0]      out_tdata,
  // [0] range_error
  output logic             out_tuser
);
  import prct_pkg::*;

  cmd_t             cmd;
  sts_t             sts;
  logic [CNT_W-1:0] count;
  logic             range_error;

  // Hold all item handling in the sequencer; the datapath only acts on
  // its commands.
  prct_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Only bit 0 of value is kept; the upper value bits and the pad are dropped.
  prct_dpath #(.ELEMENTS(ELEMENTS)) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_act    (in_tuser),
    .in_lo     (in_tdata[9:0]),
    .in_hi     (in_tdata[19:10]),
    .in_bit    (in_tdata[20]),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_count (count),
    .out_err   (range_error)
  );

  // The result register frees the input side: a new transfer is taken while
  // the previous result still waits.
  assign out_tdata = {5'b0, count};
  assign out_tuser = range_error;

endmodule
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the parity range count tree
// Drives set, even-count, odd-count and unused-action items over the input
// stream, keeps a per-element parity image to predict every query result,
// and compares each result transfer against the oldest pending prediction.
// Runs a directed opening, then random traffic under several sender/receiver
// idle mixes and one long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb;
  import prct_pkg::*;

  localparam int NUM_ELEMENTS = 1024;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  // Margin to wait for stray late results after the queue drains.
  localparam int DRAIN_CYCLES = 64;
  localparam int PHASE_ITEMS  = 120;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             range_error;
  } count_result_t;

  // Parity image of the element array plus the queue of predicted counts.
  class parity_scoreboard;
    bit            parity_bits [NUM_ELEMENTS];
    count_result_t pending_counts [$];
    int unsigned   mismatches;

    function new();
      foreach (parity_bits[i]) parity_bits[i] = 1'b0;
      mismatches = 0;
    endfunction

    // Apply an accepted input transfer; queue a prediction for queries.
    function void note_transfer(logic [ACT_W-1:0] action, logic [IDX_W-1:0] lo_idx,
                                logic [IDX_W-1:0] hi_idx, logic [VAL_W-1:0] value);
      int unsigned   odd_sum;
      count_result_t want;
      odd_sum = 0;
      want    = '0;
      case (action) inside
        ACT_SET: begin
          if (lo_idx < NUM_ELEMENTS) parity_bits[lo_idx] = value[0];
        end
        ACT_EVEN, ACT_ODD: begin
          if (hi_idx < lo_idx || hi_idx >= NUM_ELEMENTS) begin
            want.count       = '0;
            want.range_error = 1'b1;
          end else begin
            for (int i = lo_idx; i <= hi_idx; i++) odd_sum += parity_bits[i];
            if (action == ACT_ODD) want.count = odd_sum[CNT_W-1:0];
            else want.count = CNT_W'(hi_idx - lo_idx + 1 - odd_sum);
            want.range_error = 1'b0;
          end
          pending_counts = {pending_counts, want};
        end
        default: ;  // unused action: dropped by the block
      endcase
    endfunction

    task report_mismatch(string what);
      $display("[%0t] MISMATCH: %s", $realtime, what);
      mismatches++;
    endtask

    // Compare one result transfer with the oldest prediction.
    task check_result(logic [CNT_W-1:0] count, logic range_error);
      count_result_t want;
      if (pending_counts.size() == 0) begin
        report_mismatch($sformatf("unexpected result count=%0d err=%0b", count, range_error));
      end else begin
        want = pending_counts.pop_front();
        if (count !== want.count)
          report_mismatch($sformatf("count %0d, want %0d", count, want.count));
        if (range_error !== want.range_error)
          report_mismatch($sformatf("range_error %0b, want %0b",
                                    range_error, want.range_error));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  // [9:0] left_index, [19:10] right_index, [51:20] value, [55:52] zero
  logic [55:0] in_tdata   = '0;
  // [1:0] action
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [10:0] count, [15:11] zero
  logic [15:0] out_tdata;
  // [0] range_error
  logic        out_tuser;

  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned hold_request    = 0;

  parity_scoreboard sb;

  parity_range_count_tree #(
    .ELEMENTS(NUM_ELEMENTS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #3_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Monitors: sample both channels at the edge where a transfer lands.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.note_transfer(in_tuser, in_tdata[9:0], in_tdata[19:10], in_tdata[51:20]);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata[CNT_W-1:0], out_tuser);
  end

  // Receiver: stall at the current rate, or hold off entirely while a
  // requested stretch runs down. The stretch is counted here, per cycle.
  initial begin
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_request != hold_seen) begin
        hold_left = hold_request;
        hold_seen = hold_request;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Offer one item; return once it has transferred. Random idle cycles go
  // in front, with valid low, so gaps land on every phase of the block.
  task automatic send_item(logic [ACT_W-1:0] action, logic [IDX_W-1:0] lo_idx,
                           logic [IDX_W-1:0] hi_idx, logic [VAL_W-1:0] value);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= action;
    in_tdata  <= {4'b0000, value, hi_idx, lo_idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // One random item. Sets and well-formed queries dominate; reversed ranges
  // and the unused action make up the rest. Ignored items report counted=0.
  task automatic send_random_item(output bit counted);
    int unsigned      pick;
    int unsigned      lo;
    int unsigned      hi;
    int unsigned      a;
    int unsigned      b;
    logic [ACT_W-1:0] act;
    pick    = $urandom_range(0, 99);
    counted = 1'b1;
    if (pick < 45) begin
      // Half the writes land in a small window so local queries see changes.
      lo = $urandom_range(0, 1) ? $urandom_range(0, 1023) : $urandom_range(0, 63);
      send_item(ACT_SET, lo[IDX_W-1:0], IDX_W'($urandom), $urandom);
    end else if (pick < 90) begin
      act = $urandom_range(0, 1) ? ACT_ODD : ACT_EVEN;
      case ($urandom_range(0, 3))
        0: begin
          lo = $urandom_range(0, 63);
          hi = lo + $urandom_range(0, 15);
        end
        1: begin
          lo = $urandom_range(0, 1023);
          hi = lo + $urandom_range(0, 31);
          if (hi > 1023) hi = 1023;
        end
        2: begin
          a  = $urandom_range(0, 1023);
          b  = $urandom_range(0, 1023);
          lo = (a < b) ? a : b;
          hi = (a < b) ? b : a;
        end
        default: begin
          lo = $urandom_range(0, 3);
          hi = $urandom_range(1020, 1023);
        end
      endcase
      send_item(act, lo[IDX_W-1:0], hi[IDX_W-1:0], $urandom);
    end else if (pick < 96) begin
      act = $urandom_range(0, 1) ? ACT_ODD : ACT_EVEN;
      lo  = $urandom_range(1, 1023);
      hi  = $urandom_range(0, lo - 1);
      send_item(act, lo[IDX_W-1:0], hi[IDX_W-1:0], $urandom);
    end else begin
      counted = 1'b0;
      send_item(ACT_UNUSED, IDX_W'($urandom), IDX_W'($urandom), $urandom);
    end
  endtask

  task automatic run_phase(int unsigned sidle, int unsigned rstall, int unsigned items);
    int unsigned done;
    bit          counted;
    done            = 0;
    sender_idle_pct = sidle;
    recv_stall_pct  = rstall;
    while (done < items) begin
      send_random_item(counted);
      if (counted) done++;
    end
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening, no idling. The block runs its clearing pass first;
    // send_item simply waits on tready.
    send_item(ACT_ODD,  10'd0,    10'd1023, 32'h0000_0000);  // all even after reset
    send_item(ACT_EVEN, 10'd0,    10'd1023, 32'hFFFF_FFFF);  // widest count
    send_item(ACT_SET,  10'd0,    10'd1023, 32'hFFFF_FFFF);
    send_item(ACT_SET,  10'd1023, 10'd0,    32'h0000_0001);
    send_item(ACT_SET,  10'd512,  10'd1023, 32'hFFFF_FFFE);  // even onto even
    send_item(ACT_SET,  10'd511,  10'd0,    32'h8000_0001);
    send_item(ACT_ODD,  10'd0,    10'd1023, 32'h0000_0000);
    send_item(ACT_EVEN, 10'd0,    10'd1023, 32'h0000_0000);
    send_item(ACT_ODD,  10'd0,    10'd0,    32'h0000_0000);
    send_item(ACT_EVEN, 10'd1023, 10'd1023, 32'h0000_0000);
    send_item(ACT_ODD,  10'd1023, 10'd0,    32'h0000_0000);  // reversed bounds
    send_item(ACT_EVEN, 10'd5,    10'd4,    32'hFFFF_FFFF);  // reversed by one
    send_item(ACT_UNUSED, 10'd3,  10'd700,  32'hDEAD_BEEF);  // dropped
    send_item(ACT_SET,  10'd511,  10'd511,  32'h5555_5555);  // bit already set
    send_item(ACT_SET,  10'd0,    10'd0,    32'h0000_0002);  // clear element 0
    send_item(ACT_ODD,  10'd511,  10'd512,  32'h0000_0000);
    send_item(ACT_ODD,  10'd0,    10'd1023, 32'h0000_0000);
    send_item(ACT_SET,  10'd700,  10'd0,    32'hAAAA_AAAB);
    send_item(ACT_ODD,  10'd700,  10'd700,  32'h0000_0000);
    send_item(ACT_EVEN, 10'd699,  10'd701,  32'h0000_0000);

    // Random traffic under each idle mix.
    run_phase(0,  0,  PHASE_ITEMS);
    run_phase(51, 0,  PHASE_ITEMS);
    run_phase(0,  51, PHASE_ITEMS);
    run_phase(38, 38, PHASE_ITEMS);

    // Back the block up: hold the receiver off for a long stretch while the
    // sender keeps offering at full rate.
    recv_stall_pct = 0;
    hold_request   = 400;
    run_phase(0, 0, 20);

    // Drop valid and drain.
    in_tvalid <= 1'b0;
    while (sb.pending_counts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.pending_counts.size() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending_counts.size()));
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* parity_range_count_tree.f */
design/prct_pkg.sv
design/prct_ram.sv
design/prct_dpath.sv
design/prct_ctrl.sv
design/parity_range_count_tree.sv
tb/tb.sv
